FILE: hw/rtl/bmp_pkg.sv
// bmp_pkg: shared constants, beat types and build state codes for the
// binomial mod prime block. No dependencies.
`default_nettype none
package bmp_pkg;

  localparam int TABLE_SIZE = 4096;
  localparam int IDX_W      = $clog2(TABLE_SIZE);
  localparam int VAL_W      = 30;
  localparam int MU_W       = 31;
  localparam int MUL_LAT    = 4;
  localparam int PIPE_DEPTH = 1 + 2 * MUL_LAT;

  localparam logic [VAL_W-1:0] PRIME = 30'd1000000007;
  // floor(2^60 / p) for barrett reduction
  localparam logic [MU_W-1:0]  MU    = 31'd1152921496;

  typedef struct packed {
    logic [11:0] total_count;
    logic [11:0] choose_count;
  } query_t;

  typedef struct packed {
    logic [29:0] coefficient;
    logic        invalid;
  } result_t;

  // operands the table builder drives into the two multipliers
  typedef struct packed {
    logic [VAL_W-1:0] a_a;
    logic [VAL_W-1:0] a_b;
    logic [VAL_W-1:0] b_ab;
  } build_op_t;

  typedef enum logic [4:0] {
    ST_INIT  = 5'b00001,
    ST_FACT  = 5'b00010,
    ST_POW   = 5'b00100,
    ST_INV   = 5'b01000,
    ST_READY = 5'b10000
  } build_st_e;

endpackage
`default_nettype wire

FILE: hw/rtl/bmp_mulmod.sv
// bmp_mulmod: four-stage pipelined multiply modulo p with barrett reduction.
// Depends on bmp_pkg.
`default_nettype none
module bmp_mulmod (
  input  logic                      clk_i,
  input  logic                      en_i,
  input  logic [bmp_pkg::VAL_W-1:0] a_i,
  input  logic [bmp_pkg::VAL_W-1:0] b_i,
  output logic [bmp_pkg::VAL_W-1:0] res_o
);
  import bmp_pkg::*;

  localparam int PW = 2 * VAL_W;
  localparam int TW = VAL_W + 1 + MU_W;
  localparam int RW = VAL_W + 2;
  localparam logic [RW-1:0] P1 = RW'(PRIME);
  localparam logic [RW-1:0] P2 = RW'(2 * 64'(PRIME));

  logic [PW-1:0]    x_q;
  logic [TW-1:0]    t_q;
  logic [RW-1:0]    xlo2_q, xlo3_q, qp_q;
  logic [VAL_W-1:0] res_q;
  logic [RW-1:0]    r, r1, r2;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      x_q    <= PW'(a_i) * PW'(b_i);
      t_q    <= TW'(x_q[PW-1:VAL_W-1]) * TW'(MU);
      xlo2_q <= x_q[RW-1:0];
      qp_q   <= RW'(64'(t_q[TW-1:VAL_W+1]) * 64'(PRIME));
      xlo3_q <= xlo2_q;
      res_q  <= (r >= P2) ? VAL_W'(r2) : (r >= P1) ? VAL_W'(r1) : VAL_W'(r);
    end
  end

  // barrett remainder is below 3p, so at most two corrections
  assign r  = xlo3_q - qp_q;
  assign r1 = r - P1;
  assign r2 = r - P2;

  assign res_o = res_q;

endmodule
`default_nettype wire

FILE: hw/rtl/bmp_tables.sv
// bmp_tables: factorial and inverse factorial memories, the sequencer that
// fills them after reset, and the registered query reads. Depends on bmp_pkg.
`default_nettype none
module bmp_tables (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      rd_en_i,
  input  logic [bmp_pkg::IDX_W-1:0] n_i,
  input  logic [bmp_pkg::IDX_W-1:0] m_i,
  output logic [bmp_pkg::VAL_W-1:0] fact_o,
  output logic [bmp_pkg::VAL_W-1:0] invm_o,
  output logic [bmp_pkg::VAL_W-1:0] invd_o,
  input  logic [bmp_pkg::VAL_W-1:0] res_a_i,
  input  logic [bmp_pkg::VAL_W-1:0] res_b_i,
  output bmp_pkg::build_op_t        op_o,
  output logic                      ready_o
);
  import bmp_pkg::*;

  localparam logic [IDX_W-1:0] IDX_TOP = IDX_W'(TABLE_SIZE - 1);
  localparam logic [IDX_W-1:0] IDX_ONE = IDX_W'(1);
  localparam int               WT_W    = $clog2(MUL_LAT + 1);
  localparam logic [WT_W-1:0]  WT_DONE = WT_W'(MUL_LAT);
  localparam logic [VAL_W-1:0] ONE     = VAL_W'(1);

  logic [VAL_W-1:0] fact_mem [TABLE_SIZE];
  logic [VAL_W-1:0] inv_mem  [TABLE_SIZE];

  build_st_e        st_q, st_d;
  logic [IDX_W-1:0] idx_q;
  logic [VAL_W-1:0] acc_q, base_q, exp_q, pow_final;
  logic [WT_W-1:0]  wait_q;
  logic             commit;

  logic             fw_en, iw_en;
  logic [IDX_W-1:0] fw_addr, iw_addr;
  logic [VAL_W-1:0] fw_data, iw_data;

  assign commit    = (wait_q == WT_DONE);
  assign pow_final = exp_q[0] ? res_a_i : acc_q;

  always_comb begin
    st_d    = st_q;
    fw_en   = 1'b0;
    fw_addr = idx_q;
    fw_data = res_a_i;
    iw_en   = 1'b0;
    iw_addr = idx_q - IDX_ONE;
    iw_data = res_a_i;
    case (st_q)
      ST_INIT: begin
        fw_en   = 1'b1;
        fw_addr = '0;
        fw_data = ONE;
        st_d    = ST_FACT;
      end
      ST_FACT: begin
        if (commit) begin
          fw_en = 1'b1;
          if (idx_q == IDX_TOP) st_d = ST_POW;
        end
      end
      ST_POW: begin
        if (commit && exp_q[VAL_W-1:1] == '0) begin
          iw_en   = 1'b1;
          iw_addr = IDX_TOP;
          iw_data = pow_final;
          st_d    = ST_INV;
        end
      end
      ST_INV: begin
        if (commit) begin
          iw_en = 1'b1;
          if (idx_q == IDX_ONE) st_d = ST_READY;
        end
      end
      ST_READY: st_d = ST_READY;
      default:  st_d = ST_INIT;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q   <= ST_INIT;
      idx_q  <= IDX_ONE;
      acc_q  <= ONE;
      base_q <= '0;
      exp_q  <= PRIME - VAL_W'(2);
      wait_q <= '0;
    end else begin
      st_q <= st_d;
      if (commit || st_q == ST_INIT) wait_q <= '0;
      else if (st_q != ST_READY)     wait_q <= wait_q + WT_W'(1);
      if (commit) begin
        case (st_q)
          ST_FACT: begin
            if (idx_q == IDX_TOP) begin
              base_q <= res_a_i;
              acc_q  <= ONE;
            end else begin
              acc_q <= res_a_i;
              idx_q <= idx_q + IDX_ONE;
            end
          end
          ST_POW: begin
            acc_q  <= pow_final;
            base_q <= res_b_i;
            exp_q  <= exp_q >> 1;
          end
          ST_INV: begin
            acc_q <= res_a_i;
            idx_q <= idx_q - IDX_ONE;
          end
          default: acc_q <= acc_q;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (fw_en) fact_mem[fw_addr] <= fw_data;
    if (iw_en) inv_mem[iw_addr]  <= iw_data;
    if (rd_en_i) begin
      fact_o <= fact_mem[n_i];
      invm_o <= inv_mem[m_i];
      invd_o <= inv_mem[n_i - m_i];
    end
  end

  always_comb begin
    op_o.a_a  = acc_q;
    op_o.a_b  = (st_q == ST_POW) ? base_q : VAL_W'(idx_q);
    op_o.b_ab = base_q;
  end

  assign ready_o = (st_q == ST_READY);

endmodule
`default_nettype wire

FILE: hw/rtl/binomial_mod_prime_top.sv
// binomial_mod_prime_top: query pipeline for n choose m mod p around the
// table memories. Depends on bmp_pkg, bmp_tables and bmp_mulmod.
//
//   channel | direction | beat                         | handshake
//   in      | input     | query_t  (n, m)              | in_valid_i / in_stall_o
//   out     | output    | result_t (coefficient, flag) | out_valid_o / out_stall_i
//
// one query per cycle while the output is not stalled; a result passes through one
// memory read plus two four-stage modular multipliers in series.
// after reset the tables are built through the same multipliers in two
// chains of 4095 steps plus 30 exponent steps; queries are stalled until
// the build is done.
// a stalled result freezes the whole pipeline and stalls the input.
`default_nettype none
module binomial_mod_prime_top (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_stall_o,
  input  bmp_pkg::query_t  in_data_i,
  output logic             out_valid_o,
  input  logic             out_stall_i,
  output bmp_pkg::result_t out_data_o
);
  import bmp_pkg::*;

  logic                  ready, pipe_en, mul_en, accept;
  logic [VAL_W-1:0]      fact_rd, invm_rd, invd_rd, res_a, res_b;
  logic [VAL_W-1:0]      a_a, a_b, b_a, b_b;
  logic [VAL_W-1:0]      invd_dly_q [MUL_LAT];
  logic [PIPE_DEPTH-1:0] v_q, bad_q;
  build_op_t             op;
  result_t               out_q;
  logic                  out_valid_q;

  assign pipe_en    = !out_valid_q || !out_stall_i;
  assign mul_en     = !ready || pipe_en;
  assign in_stall_o = !ready || !pipe_en;
  assign accept     = in_valid_i && !in_stall_o;

  bmp_tables u_tables (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .rd_en_i (pipe_en),
    .n_i     (in_data_i.total_count),
    .m_i     (in_data_i.choose_count),
    .fact_o  (fact_rd),
    .invm_o  (invm_rd),
    .invd_o  (invd_rd),
    .res_a_i (res_a),
    .res_b_i (res_b),
    .op_o    (op),
    .ready_o (ready)
  );

  assign a_a = ready ? fact_rd : op.a_a;
  assign a_b = ready ? invm_rd : op.a_b;
  assign b_a = ready ? res_a : op.b_ab;
  assign b_b = ready ? invd_dly_q[MUL_LAT-1] : op.b_ab;

  bmp_mulmod u_mul_a (.clk_i(clk_i), .en_i(mul_en), .a_i(a_a), .b_i(a_b), .res_o(res_a));
  bmp_mulmod u_mul_b (.clk_i(clk_i), .en_i(mul_en), .a_i(b_a), .b_i(b_b), .res_o(res_b));

  // lines inv((n-m)!) up with the first product
  always_ff @(posedge clk_i) begin
    if (pipe_en) begin
      invd_dly_q[0] <= invd_rd;
      for (int k = 1; k < MUL_LAT; k++) invd_dly_q[k] <= invd_dly_q[k-1];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q         <= '0;
      bad_q       <= '0;
      out_valid_q <= 1'b0;
    end else if (pipe_en) begin
      v_q         <= {v_q[PIPE_DEPTH-2:0], accept};
      bad_q       <= {bad_q[PIPE_DEPTH-2:0],
                      in_data_i.choose_count > in_data_i.total_count};
      out_valid_q <= v_q[PIPE_DEPTH-1];
    end
  end

  always_ff @(posedge clk_i) begin
    if (pipe_en) begin
      out_q.invalid     <= bad_q[PIPE_DEPTH-1];
      out_q.coefficient <= bad_q[PIPE_DEPTH-1] ? '0 : res_b;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule
`default_nettype wire

FILE: hw/rtl/bmp_checker.sv
// bmp_checker: port-level checks on the binomial mod prime top level, bound
// to it below. Depends on bmp_pkg.
`default_nettype none
module bmp_checker (
  input logic             clk_i,
  input logic             rst_ni,
  input logic             in_valid_i,
  input logic             in_stall_o,
  input logic             out_valid_o,
  input logic             out_stall_i,
  input bmp_pkg::result_t out_data_o
);
  import bmp_pkg::*;

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o) else $error("out beat dropped");

  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> $stable(out_data_o)) else $error("out beat changed");

  a_in_backpressure: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |-> !(in_valid_i && !in_stall_o))
    else $error("input taken while frozen");

  a_invalid_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.invalid |-> out_data_o.coefficient == '0)
    else $error("invalid beat with nonzero coefficient");

  a_reduced: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> out_data_o.coefficient < PRIME) else $error("coefficient not reduced");

endmodule

bind binomial_mod_prime_top bmp_checker u_bmp_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_stall_o  (in_stall_o),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .out_data_o  (out_data_o)
);
`default_nettype wire

FILE: tb/binomial_mod_prime_top_tb.sv
// binomial_mod_prime_top_tb: self-checking bench for the n choose m mod p block.
// Needs bmp_pkg and binomial_mod_prime_top; the factorial tables are rebuilt
// locally and every result beat is checked in order.
`timescale 1ns / 100ps
`default_nettype none
module binomial_mod_prime_top_tb;
  import bmp_pkg::*;

  localparam longint P_MOD = 64'd1000000007;
  localparam int WATCHDOG_LIMIT = 200000;

  logic    clk_i = 1'b0;
  logic    rst_ni = 1'b0;
  logic    in_valid_i = 1'b0;
  logic    in_stall_o;
  query_t  in_data_i = '0;
  logic    out_valid_o;
  logic    out_stall_i = 1'b0;
  result_t out_data_o;

  binomial_mod_prime_top DUT (
    .clk_i(clk_i), .rst_ni(rst_ni),
    .in_valid_i(in_valid_i), .in_stall_o(in_stall_o), .in_data_i(in_data_i),
    .out_valid_o(out_valid_o), .out_stall_i(out_stall_i), .out_data_o(out_data_o)
  );

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  longint  fact_tab [TABLE_SIZE];
  longint  inv_fact_tab [TABLE_SIZE];
  query_t  pending_queries [$];
  result_t expected_coeffs [$];
  int      mismatch_count = 0;
  int      idle_cycles = 0;
  bit      in_taken = 1'b0;
  bit      hold_sender = 1'b0;
  int      send_gap = 0;
  int      stall_len = 0;

  function automatic longint mulmod(longint a, longint b);
    return (a * b) % P_MOD;
  endfunction

  function automatic longint powmod(longint b, longint e);
    longint acc;
    acc = 1;
    while (e != 0) begin
      if (e[0]) acc = mulmod(acc, b);
      b = mulmod(b, b);
      e = e >> 1;
    end
    return acc;
  endfunction

  function automatic result_t binom_expected(query_t q);
    result_t r;
    int n;
    int m;
    n = q.total_count;
    m = q.choose_count;
    r = '0;
    if (m == 0) r.coefficient = 30'd1;
    else if (m > n || n >= TABLE_SIZE) r.invalid = 1'b1;
    else r.coefficient = 30'(mulmod(mulmod(fact_tab[n], inv_fact_tab[m]),
                                    inv_fact_tab[n-m]));
    return r;
  endfunction

  function automatic int rand_gap();
    if ($urandom_range(0, 2) == 0) return 0;
    if ($urandom_range(0, 19) == 0) return $urandom_range(10, 60);
    return $urandom_range(0, 3);
  endfunction

  // driver: next beat set up on the falling edge once the previous one went in
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (in_valid_i && in_taken) begin
        if (send_gap == 0 && !hold_sender && pending_queries.size() > 0) begin
          in_data_i <= pending_queries.pop_front();
          send_gap <= rand_gap();
        end else begin
          in_valid_i <= 1'b0;
        end
      end else if (!in_valid_i) begin
        if (send_gap > 0) send_gap <= send_gap - 1;
        else if (!hold_sender && pending_queries.size() > 0) begin
          in_data_i <= pending_queries.pop_front();
          in_valid_i <= 1'b1;
          send_gap <= rand_gap();
        end
      end
      if (stall_len > 0) begin
        out_stall_i <= 1'b1;
        stall_len <= stall_len - 1;
      end else begin
        out_stall_i <= 1'b0;
        stall_len <= rand_gap();
      end
    end
  end

  // predictor on the input side, checker on the output side
  always @(posedge clk_i) begin
    if (rst_ni) begin
      in_taken <= in_valid_i && !in_stall_o;
      if (in_valid_i && !in_stall_o)
        expected_coeffs = {expected_coeffs, binom_expected(in_data_i)};
      if (out_valid_o && !out_stall_i) begin
        if (expected_coeffs.size() == 0) begin
          mismatch_count++;
          if (mismatch_count <= 10) $display("unexpected result beat %h", out_data_o);
        end else begin
          result_t exp_r;
          exp_r = expected_coeffs.pop_front();
          if (exp_r.coefficient !== out_data_o.coefficient ||
              exp_r.invalid !== out_data_o.invalid) begin
            mismatch_count++;
            if (mismatch_count <= 10)
              $display("mismatch: exp coef %0d inv %0b, got coef %0d inv %0b",
                       exp_r.coefficient, exp_r.invalid,
                       out_data_o.coefficient, out_data_o.invalid);
          end
        end
      end
      if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("DONE: errors detected");
        $finish;
      end
    end
  end

  task automatic add_query(int n, int m);
    query_t q;
    q.total_count = 12'(n);
    q.choose_count = 12'(m);
    pending_queries = {pending_queries, q};
  endtask

  initial begin
    int i;
    int n;
    fact_tab[0] = 1;
    for (i = 1; i < TABLE_SIZE; i++) fact_tab[i] = mulmod(fact_tab[i-1], i);
    inv_fact_tab[TABLE_SIZE-1] = powmod(fact_tab[TABLE_SIZE-1], P_MOD - 2);
    for (i = TABLE_SIZE - 1; i > 0; i--) inv_fact_tab[i-1] = mulmod(inv_fact_tab[i], i);

    // queued before tables are ready so the first beats wait on the build
    add_query(0, 0);      add_query(4095, 0);    add_query(4095, 4095);
    add_query(4095, 1);   add_query(4095, 4094); add_query(4095, 2048);
    add_query(1, 1);      add_query(1, 0);       add_query(0, 1);
    add_query(0, 4095);   add_query(4094, 4095); add_query(10, 3);
    add_query(2730, 1365); add_query(1365, 2730); add_query(3, 3);
    add_query(100, 50);   add_query(4095, 2047);

    repeat (2) @(posedge clk_i);
    @(negedge clk_i) rst_ni = 1'b1;

    wait (pending_queries.size() == 0);
    @(posedge clk_i);
    wait (!in_valid_i);
    wait (expected_coeffs.size() == 0);
    for (i = 0; i < 1800; i++) begin
      case ($urandom_range(0, 9))
        0: add_query($urandom_range(0, 4095), $urandom_range(0, 4095));
        1: begin
          n = $urandom_range(0, 4094);
          add_query(n, $urandom_range(n + 1, 4095));
        end
        2: add_query($urandom_range(0, 4095), 0);
        default: begin
          n = $urandom_range(0, 4095);
          add_query(n, $urandom_range(0, n));
        end
      endcase
      // hold-off: let the first half go out, then drain everything in flight
      if (i == 900) begin
        wait (pending_queries.size() == 0);
        hold_sender = 1'b1;
        @(posedge clk_i);
        wait (expected_coeffs.size() == 0 && !in_valid_i);
        hold_sender = 1'b0;
      end
    end
    wait (pending_queries.size() == 0);
    @(posedge clk_i);
    wait (!in_valid_i);
    wait (expected_coeffs.size() == 0);
    repeat (20) @(posedge clk_i);
    if (mismatch_count == 0 && expected_coeffs.size() == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
`default_nettype wire
